### src/http_request_head_parser_assert.svh
// Assertion macros for the HTTP request head parser.
`ifndef HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_PARSER_ASSERT_SVH

// Check cons in the same cycle as ante.
`define HRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define HRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/hrp_pkg.sv
// Shared types and constants of the HTTP request head parser.
`default_nettype none

package hrp_pkg;

  localparam logic [2:0] FK_METHOD  = 3'd0;
  localparam logic [2:0] FK_URL     = 3'd1;
  localparam logic [2:0] FK_VERSION = 3'd2;
  localparam logic [2:0] FK_KEY     = 3'd3;
  localparam logic [2:0] FK_VALUE   = 3'd4;

  localparam logic [2:0] EV_CONTENT   = 3'd0;
  localparam logic [2:0] EV_LINE_OK   = 3'd1;
  localparam logic [2:0] EV_HEADER_OK = 3'd2;
  localparam logic [2:0] EV_DONE      = 3'd3;
  localparam logic [2:0] EV_ERROR     = 3'd4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [3:0] VER_LEN = 4'd8;
  localparam logic [0:7][7:0] VER_ONE  = "http/1.1";
  localparam logic [0:7][7:0] VER_ZERO = "http/1.0";

  localparam logic [2:0] RQ_FULL_LVL = 3'd4;
  localparam logic [2:0] RQ_ROOM_LVL = 3'd2;

  typedef enum logic [2:0] {
    PH_LINE = 3'b001,
    PH_HEAD = 3'b010,
    PH_ERR  = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic [2:0] kind;
    logic [2:0] ev;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

### src/http_request_head_parser.sv
// Flow: a taken byte is registered, its results go into the result queue when
// it has room, and are offered from there. Throughput: one byte per cycle
// while the output is not stalled and each byte yields at most one result;
// bytes with two results can hold the input back, as the single result port drains a four-entry result queue.
// Reset: parser returns to the request line, the queue empties; an error
// holds until reset.
`default_nettype none

`include "http_request_head_parser_assert.svh"

module http_request_head_parser (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [2:0]      field_kind,
  output logic [2:0]      event_res,
  output logic            last
);
  import hrp_pkg::*;

  logic       room;
  logic [1:0] push_n;
  res_t [1:0] res;
  res_t       head;
  logic [2:0] level;
  logic       pop;

  assign room      = (level <= RQ_ROOM_LVL);
  assign out_valid = (level != 3'd0);
  assign pop       = out_valid && !out_stall;

  hrp_core u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .room     (room),
    .push_n   (push_n),
    .res      (res)
  );

  hrp_rfifo u_rfifo (
    .clk    (clk),
    .rst    (rst),
    .push_n (push_n),
    .wdata  (res),
    .pop    (pop),
    .rdata  (head),
    .level  (level)
  );

  assign out_byte   = head.data;
  assign field_kind = head.kind;
  assign event_res  = head.ev;
  assign last       = head.last;

  `HRP_ASSERT_NOW(a_level_bound, 1'b1, level <= RQ_FULL_LVL, "result queue overflow")
  `HRP_ASSERT_NOW(a_push_room, push_n != 2'd0, room, "push without queue room")
  `HRP_ASSERT_NEXT(a_idle_empty, level == 3'd0 && push_n == 2'd0, !out_valid,
    "result shown from empty queue")

endmodule

`default_nettype wire

### src/hrp_core.sv
// Input register and parse step of the HTTP request head parser.
`default_nettype none

module hrp_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [7:0]             in_byte,
  input  wire logic                   room,
  output logic [1:0]                  push_n,
  output hrp_pkg::res_t [1:0]         res
);
  import hrp_pkg::*;

  typedef struct packed {
    phase_t     phase;
    logic [2:0] cur;
    logic       seen;
    logic       hcolon;
    logic       hcr;
    logic [3:0] vidx;
    logic       vm1;
    logic       vm0;
    logic       empty;
  } st_t;

  localparam st_t ST_RESET = '{
    phase: PH_LINE, cur: FK_METHOD, seen: 1'b0, hcolon: 1'b0, hcr: 1'b0,
    vidx: 4'd0, vm1: 1'b1, vm0: 1'b1, empty: 1'b1
  };

  function automatic res_t mk(logic [7:0] d, logic [2:0] k, logic [2:0] e);
    res_t r;
    r.data = d;
    r.kind = k;
    r.ev   = e;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic st_t take(st_t s, logic [7:0] b);
    logic [7:0] low;
    low = (b inside {[CH_UP_A:CH_UP_Z]}) ? b + CASE_OFS : b;
    s.seen  = 1'b1;
    s.empty = 1'b0;
    if (s.phase == PH_LINE && s.cur == FK_VERSION) begin
      if (s.vidx < VER_LEN) begin
        if (low != VER_ONE[s.vidx[2:0]]) s.vm1 = 1'b0;
        if (low != VER_ZERO[s.vidx[2:0]]) s.vm0 = 1'b0;
        s.vidx = s.vidx + 4'd1;
      end else begin
        s.vm1 = 1'b0;
        s.vm0 = 1'b0;
      end
    end
    return s;
  endfunction

  function automatic st_t newl(st_t s);
    s.seen   = 1'b0;
    s.hcolon = 1'b0;
    s.hcr    = 1'b0;
    s.vidx   = 4'd0;
    s.vm1    = 1'b1;
    s.vm0    = 1'b1;
    s.empty  = 1'b1;
    return s;
  endfunction

  function automatic st_t fail(st_t s);
    s.phase  = PH_ERR;
    s.hcolon = 1'b0;
    s.hcr    = 1'b0;
    return s;
  endfunction

  logic       in_full;
  logic [7:0] in_byte_r;
  logic       adv;
  st_t        st;
  st_t        nx;
  logic [1:0] n;
  res_t [1:0] rs;
  logic [7:0] b;
  logic       do_plain;
  logic       skip;

  assign adv      = in_full && room;
  assign in_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_RESET;
    end else if (adv) begin
      st <= nx;
    end
  end

  always_comb begin
    nx       = st;
    n        = 2'd0;
    rs       = '0;
    b        = in_byte_r;
    do_plain = 1'b0;
    skip     = 1'b0;
    if (st.phase == PH_LINE || st.phase == PH_HEAD) begin
      do_plain = 1'b1;
      if (nx.cur > FK_VALUE) nx.cur = FK_METHOD;
      if (nx.hcr) begin
        nx.hcr = 1'b0;
        if (b == CH_LF) begin
          do_plain = 1'b0;
          if (nx.phase == PH_LINE) begin
            if (nx.cur == FK_VERSION && nx.seen && nx.vidx == VER_LEN &&
                (nx.vm1 || nx.vm0)) begin
              rs[n[0]] = mk(8'd0, FK_METHOD, EV_LINE_OK);
              n        = n + 2'd1;
              nx.phase = PH_HEAD;
              nx.cur   = FK_KEY;
              nx       = newl(nx);
            end else begin
              rs[n[0]] = mk(8'd0, FK_METHOD, EV_ERROR);
              n        = n + 2'd1;
              nx       = fail(nx);
            end
          end else if (nx.cur == FK_KEY) begin
            if (nx.empty) begin
              rs[n[0]] = mk(8'd0, FK_METHOD, EV_DONE);
              n        = n + 2'd1;
              nx.phase = PH_LINE;
              nx.cur   = FK_METHOD;
              nx       = newl(nx);
            end else begin
              rs[n[0]] = mk(8'd0, FK_METHOD, EV_ERROR);
              n        = n + 2'd1;
              nx       = fail(nx);
            end
          end else if (nx.seen) begin
            rs[n[0]] = mk(8'd0, FK_METHOD, EV_HEADER_OK);
            n        = n + 2'd1;
            nx.cur   = FK_KEY;
            nx       = newl(nx);
          end else begin
            rs[n[0]] = mk(8'd0, FK_METHOD, EV_ERROR);
            n        = n + 2'd1;
            nx       = fail(nx);
          end
        end else begin
          rs[n[0]] = mk(CH_CR, nx.cur, EV_CONTENT);
          n        = n + 2'd1;
          nx       = take(nx, CH_CR);
        end
      end
      if (do_plain) begin
        if (nx.phase == PH_LINE) begin
          if (b == CH_CR) begin
            nx.hcr = 1'b1;
          end else if (b == CH_SP && nx.cur != FK_VERSION) begin
            if (!nx.seen) begin
              rs[n[0]] = mk(8'd0, FK_METHOD, EV_ERROR);
              n        = n + 2'd1;
              nx       = fail(nx);
            end else begin
              nx.cur   = nx.cur + 3'd1;
              nx.seen  = 1'b0;
              nx.empty = 1'b0;
            end
          end else begin
            rs[n[0]] = mk(b, nx.cur, EV_CONTENT);
            n        = n + 2'd1;
            nx       = take(nx, b);
          end
        end else if (nx.cur == FK_KEY) begin
          if (nx.hcolon) begin
            nx.hcolon = 1'b0;
            if (b == CH_SP) begin
              skip = 1'b1;
              if (!nx.seen) begin
                rs[n[0]] = mk(8'd0, FK_METHOD, EV_ERROR);
                n        = n + 2'd1;
                nx       = fail(nx);
              end else begin
                nx.cur  = FK_VALUE;
                nx.seen = 1'b0;
              end
            end else begin
              rs[n[0]] = mk(CH_COLON, nx.cur, EV_CONTENT);
              n        = n + 2'd1;
              nx       = take(nx, CH_COLON);
            end
          end
          if (!skip) begin
            if (b == CH_COLON) begin
              nx.hcolon = 1'b1;
              nx.empty  = 1'b0;
            end else if (b == CH_CR) begin
              nx.hcr = 1'b1;
            end else begin
              rs[n[0]] = mk(b, nx.cur, EV_CONTENT);
              n        = n + 2'd1;
              nx       = take(nx, b);
            end
          end
        end else begin
          if (b == CH_CR) begin
            nx.hcr = 1'b1;
          end else begin
            rs[n[0]] = mk(b, nx.cur, EV_CONTENT);
            n        = n + 2'd1;
            nx       = take(nx, b);
          end
        end
      end
    end
    rs[0].last = (n == 2'd1);
    rs[1].last = 1'b1;
  end

  assign push_n = adv ? n : 2'd0;
  assign res    = rs;

endmodule

`default_nettype wire

### src/hrp_rfifo.sv
// Four-entry result queue taking up to two results per cycle.
`default_nettype none

module hrp_rfifo (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [1:0]             push_n,
  input  wire hrp_pkg::res_t [1:0]    wdata,
  input  wire logic                   pop,
  output hrp_pkg::res_t               rdata,
  output logic [2:0]                  level
);
  import hrp_pkg::*;

  res_t       mem [4];
  logic [1:0] wp;
  logic [1:0] wp1;
  logic [1:0] rp;

  assign wp1 = wp + 2'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 2'd0;
      rp    <= 2'd0;
      level <= 3'd0;
    end else begin
      wp    <= wp + push_n;
      rp    <= rp + {1'b0, pop};
      level <= level + {1'b0, push_n} - {2'b00, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wp] <= wdata[0];
    end
    if (push_n == 2'd2) begin
      mem[wp1] <= wdata[1];
    end
  end

  assign rdata = mem[rp];

endmodule

`default_nettype wire

### bench/http_head_checker.sv
// Watches both channels of the request head parser, predicts every result beat and compares.
`timescale 1ns / 100ps

module http_head_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [2:0] field_kind,
  input  logic [2:0] event_res,
  input  logic       last,
  output int         fail_count,
  output int         pending
);
  import hrp_pkg::*;

  phase_t     ph;
  logic [2:0] field;
  logic       seen_byte;
  logic       colon_held;
  logic       cr_held;
  logic [3:0] ver_pos;
  logic       ver1_ok;
  logic       ver0_ok;
  logic       line_blank;

  res_t step_beats[$];
  res_t expected_beats[$];
  res_t front;
  int   mismatches = 0;

  task report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("%0t: mismatch on %s: got 0x%h, want 0x%h", $time, what, got, want);
    mismatches++;
  endtask

  function void add_beat(logic [7:0] data, logic [2:0] kind, logic [2:0] ev);
    res_t r;
    r.data = data;
    r.kind = kind;
    r.ev   = ev;
    r.last = 1'b0;
    if (step_beats.size() < 2) step_beats.push_back(r);
  endfunction

  function void restart_line();
    seen_byte  = 1'b0;
    colon_held = 1'b0;
    cr_held    = 1'b0;
    ver_pos    = 4'd0;
    ver1_ok    = 1'b1;
    ver0_ok    = 1'b1;
    line_blank = 1'b1;
  endfunction

  function void raise_error();
    ph         = PH_ERR;
    colon_held = 1'b0;
    cr_held    = 1'b0;
    add_beat(8'h00, FK_METHOD, EV_ERROR);
  endfunction

  function void take_content(logic [7:0] b);
    logic [7:0] low;
    add_beat(b, field, EV_CONTENT);
    seen_byte  = 1'b1;
    line_blank = 1'b0;
    if (ph == PH_LINE && field == FK_VERSION) begin
      if (ver_pos < VER_LEN) begin
        low = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFS : b;
        if (low != VER_ONE[ver_pos[2:0]]) ver1_ok = 1'b0;
        if (low != VER_ZERO[ver_pos[2:0]]) ver0_ok = 1'b0;
        ver_pos = ver_pos + 4'd1;
      end else begin
        ver1_ok = 1'b0;
        ver0_ok = 1'b0;
      end
    end
  endfunction

  function void close_line();
    if (ph == PH_LINE) begin
      if (field == FK_VERSION && seen_byte && ver_pos == VER_LEN && (ver1_ok || ver0_ok)) begin
        add_beat(8'h00, FK_METHOD, EV_LINE_OK);
        ph    = PH_HEAD;
        field = FK_KEY;
        restart_line();
      end else begin
        raise_error();
      end
    end else if (field == FK_KEY) begin
      if (line_blank) begin
        add_beat(8'h00, FK_METHOD, EV_DONE);
        ph    = PH_LINE;
        field = FK_METHOD;
        restart_line();
      end else begin
        raise_error();
      end
    end else if (seen_byte) begin
      add_beat(8'h00, FK_METHOD, EV_HEADER_OK);
      field = FK_KEY;
      restart_line();
    end else begin
      raise_error();
    end
  endfunction

  function void plain_byte(logic [7:0] b);
    if (ph == PH_LINE) begin
      if (b == CH_CR) begin
        cr_held = 1'b1;
      end else if (b == CH_SP && field != FK_VERSION) begin
        if (!seen_byte) begin
          raise_error();
        end else begin
          field      = field + 3'd1;
          seen_byte  = 1'b0;
          line_blank = 1'b0;
        end
      end else begin
        take_content(b);
      end
    end else if (field == FK_KEY) begin
      if (colon_held) begin
        colon_held = 1'b0;
        if (b == CH_SP) begin
          if (!seen_byte) begin
            raise_error();
          end else begin
            field     = FK_VALUE;
            seen_byte = 1'b0;
          end
          return;
        end
        take_content(CH_COLON);
      end
      if (b == CH_COLON) begin
        colon_held = 1'b1;
        line_blank = 1'b0;
      end else if (b == CH_CR) begin
        cr_held = 1'b1;
      end else begin
        take_content(b);
      end
    end else if (b == CH_CR) begin
      cr_held = 1'b1;
    end else begin
      take_content(b);
    end
  endfunction

  function void parse_byte(logic [7:0] b);
    res_t r;
    int   n;
    step_beats.delete();
    if (ph == PH_LINE || ph == PH_HEAD) begin
      if (field > FK_VALUE) field = FK_METHOD;
      if (cr_held) begin
        cr_held = 1'b0;
        if (b == CH_LF) begin
          close_line();
        end else begin
          take_content(CH_CR);
          plain_byte(b);
        end
      end else begin
        plain_byte(b);
      end
      n = step_beats.size();
      for (int i = 0; i < n; i++) begin
        r      = step_beats[i];
        r.last = (i == n - 1);
        expected_beats.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      ph    = PH_LINE;
      field = FK_METHOD;
      restart_line();
      expected_beats.delete();
    end else begin
      if (in_valid && !in_stall) parse_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("beat with no result pending", out_byte, 8'h00);
        end else begin
          front = expected_beats.pop_front();
          if (out_byte !== front.data) report_mismatch("out_byte", out_byte, front.data);
          if (field_kind !== front.kind)
            report_mismatch("field_kind", {5'b0, field_kind}, {5'b0, front.kind});
          if (event_res !== front.ev)
            report_mismatch("event_res", {5'b0, event_res}, {5'b0, front.ev});
          if (last !== front.last) report_mismatch("last", {7'b0, last}, {7'b0, front.last});
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_beats.size();
  end

endmodule

### bench/http_request_head_parser_tb.sv
// Drives request heads into the HTTP request head parser and gives the verdict.
`timescale 1ns / 100ps

module http_request_head_parser_tb;
  import hrp_pkg::*;

  typedef enum int {
    BRK_EMPTY_METHOD,
    BRK_EMPTY_URL,
    BRK_END_IN_METHOD,
    BRK_END_IN_URL,
    BRK_BAD_VERSION,
    BRK_EMPTY_LINE,
    BRK_NO_SEPARATOR,
    BRK_EMPTY_VALUE,
    BRK_EMPTY_KEY
  } broken_t;

  localparam logic [0:26][7:0] OPENING = {
    8'hFF, CH_SP, 8'h00, CH_CR, 8'h7F, CH_LF, CH_SP, "hTtP/1.0", CH_CR, CH_LF,
    "a:b: c", CH_CR, CH_LF, CH_CR, CH_LF
  };

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] field_kind;
  logic [2:0] event_res;
  logic       last;

  int fail_count;
  int pending;
  int tx_idle    = 11;
  int rx_idle    = 80;
  int sent_count = 0;
  bit hold_done  = 1'b0;

  http_request_head_parser DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .field_kind (field_kind),
    .event_res  (event_res),
    .last       (last)
  );

  http_head_checker head_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .field_kind (field_kind),
    .event_res  (event_res),
    .last       (last),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!hold_done && sent_count >= 120) begin
        hold      = 60;
        hold_done = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic [7:0] pick_byte(logic [7:0] prev, logic [2:0] kind);
    logic [7:0] b;
    do begin
      case ($urandom_range(7))
        0:       b = CH_CR;
        1:       b = CH_LF;
        2:       b = CH_COLON;
        3:       b = CH_SP;
        4, 5:    b = 8'($urandom_range(126, 33));
        default: b = 8'($urandom_range(255));
      endcase
    end while ((prev == CH_CR && b == CH_LF) ||
               ((kind == FK_METHOD || kind == FK_URL) && b == CH_SP) ||
               (kind == FK_KEY && prev == CH_COLON && b == CH_SP));
    return b;
  endfunction

  function automatic int field_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
  endfunction

  task automatic send_field(logic [2:0] kind, int count);
    logic [7:0] prev;
    logic [7:0] b;
    prev = 8'h00;
    for (int i = 0; i < count; i++) begin
      b = pick_byte(prev, kind);
      send_byte(b);
      prev = b;
    end
  endtask

  task automatic send_request_line();
    logic [0:7][7:0] ver;
    logic [7:0]      c;
    ver = $urandom_range(1) ? VER_ONE : VER_ZERO;
    send_field(FK_METHOD, field_len());
    send_byte(CH_SP);
    send_field(FK_URL, field_len());
    send_byte(CH_SP);
    for (int i = 0; i < 8; i++) begin
      c = ver[i];
      if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - CASE_OFS;
      send_byte(c);
    end
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  initial begin
    int      stage;
    broken_t brk;
    stage = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < 27; i++) send_byte(OPENING[i]);

    while (sent_count < 700) begin
      if ((stage == 0 && sent_count >= 240) || (stage == 1 && sent_count >= 470)) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        stage++;
        tx_idle = (stage == 1) ? 80 : 0;
        rx_idle = (stage == 1) ? 11 : 0;
      end
      send_request_line();
      repeat ($urandom_range(0, 3)) begin
        send_field(FK_KEY, field_len());
        send_byte(CH_COLON);
        send_byte(CH_SP);
        send_field(FK_VALUE, field_len());
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      send_byte(CH_CR);
      send_byte(CH_LF);
    end

    // end the stream with one malformed head; the parser then ignores everything
    brk = broken_t'($urandom_range(BRK_EMPTY_KEY));
    if (brk >= BRK_NO_SEPARATOR) send_request_line();
    case (brk)
      BRK_EMPTY_METHOD: send_byte(CH_SP);
      BRK_EMPTY_URL: begin
        send_field(FK_METHOD, field_len());
        send_byte(CH_SP);
        send_byte(CH_SP);
      end
      BRK_END_IN_METHOD: begin
        send_field(FK_METHOD, field_len());
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      BRK_END_IN_URL: begin
        send_field(FK_METHOD, field_len());
        send_byte(CH_SP);
        send_field(FK_URL, field_len());
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      BRK_BAD_VERSION: begin
        send_field(FK_METHOD, field_len());
        send_byte(CH_SP);
        send_field(FK_URL, field_len());
        send_byte(CH_SP);
        send_field(FK_VALUE, $urandom_range(1, 7));
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      BRK_EMPTY_LINE: begin
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      BRK_NO_SEPARATOR: begin
        send_field(FK_KEY, field_len());
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      BRK_EMPTY_VALUE: begin
        send_field(FK_KEY, field_len());
        send_byte(CH_COLON);
        send_byte(CH_SP);
        send_byte(CH_CR);
        send_byte(CH_LF);
      end
      default: begin
        send_byte(CH_COLON);
        send_byte(CH_SP);
      end
    endcase
    repeat (40) send_byte(8'($urandom_range(255)));

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+src
src/hrp_pkg.sv
src/hrp_core.sv
src/hrp_rfifo.sv
src/http_request_head_parser.sv
bench/http_head_checker.sv
bench/http_request_head_parser_tb.sv
